FILE: rtl/core/nalb_pkg.sv
// Shared types and constants of the network activity LED blinker.
`default_nettype none

package nalb_pkg;

    // Command codes carried by a request.
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_LINK      = 2'd1;
    localparam logic [1:0] CMD_ACT_BEGIN = 2'd2;
    localparam logic [1:0] CMD_ACT_END   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ON_MIN     = 3'd0;
    localparam logic [2:0] REG_ON_MAX     = 3'd1;
    localparam logic [2:0] REG_OFF_MIN    = 3'd2;
    localparam logic [2:0] REG_OFF_MAX    = 3'd3;
    localparam logic [2:0] REG_PULSES     = 3'd4;
    localparam logic [2:0] REG_MAX_BUDGET = 3'd5;
    localparam logic [2:0] REG_TAIL       = 3'd6;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] on_min_ms;
        logic [15:0] on_max_ms;
        logic [15:0] off_min_ms;
        logic [15:0] off_max_ms;
        logic [7:0]  pulses_per_activity;
        logic [7:0]  max_pulse_budget;
        logic [15:0] tail_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        connected;
        logic [15:0] random_draw;
    } item_t;

    typedef struct packed {
        logic        led_lit;
        logic        phase_lit;
        logic        blinking;
        logic [7:0]  pulses_left;
        logic [15:0] activity_depth;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/nalb_phase_len.sv
// Random phase length: min + ((draw * span) >> 16), or min when max <= min, saturated to the counter range.
`default_nettype none

module nalb_phase_len #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic [15:0]           lo,
    input  wire logic [15:0]           hi,
    input  wire logic [15:0]           draw,
    output logic      [TIME_WIDTH-1:0] len
);

    localparam int SW = TIME_WIDTH + 18;
    localparam logic [SW-1:0] TMAX = {{18{1'b0}}, {TIME_WIDTH{1'b1}}};

    logic [16:0] span;
    logic [32:0] product;
    logic [17:0] sum;
    logic [SW-1:0] sum_ext;

    assign span    = {1'b0, hi} - {1'b0, lo} + 17'd1;
    assign product = {17'd0, draw} * {16'd0, span};

    always_comb
    begin
        if (hi <= lo)
        begin
            sum = {2'b00, lo};
        end
        else
        begin
            sum = {2'b00, lo} + {1'b0, product[32:16]};
        end
        sum_ext = {{TIME_WIDTH{1'b0}}, sum};
        if (sum_ext > TMAX)
        begin
            len = {TIME_WIDTH{1'b1}};
        end
        else
        begin
            len = sum_ext[TIME_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nalb_core.sv
// Blinker state registers and the single-pass update for one request.
`default_nettype none

module nalb_core #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire nalb_pkg::item_t item,
    input  wire nalb_pkg::cfg_t  cfg,
    output nalb_pkg::res_t       res
);

    localparam int TW = TIME_WIDTH + 16;
    localparam logic [TW-1:0] TMAX = {{16{1'b0}}, {TIME_WIDTH{1'b1}}};

    logic                  link_reg, link_next;
    logic [15:0]           open_reg, open_next;
    logic [7:0]            budget_reg, budget_next;
    logic [TIME_WIDTH-1:0] tail_reg, tail_next;
    logic [TIME_WIDTH-1:0] phase_reg, phase_next;
    logic                  is_lit_reg, is_lit_next;
    logic                  running_reg, running_next;

    logic                  lit_sel;
    logic [15:0]           len_lo;
    logic [15:0]           len_hi;
    logic [TIME_WIDTH-1:0] len;
    logic [TW-1:0]         tail_ext;
    logic [TIME_WIDTH-1:0] tail_load;
    logic [8:0]            budget_sum;
    logic                  blink;

    // On a tick the phase that may start is the opposite of the one ending,
    // or a lit one when no phase runs; for every other command it is a lit one.
    assign lit_sel = (item.cmd == nalb_pkg::CMD_TICK) ? (!running_reg || !is_lit_reg) : 1'b1;
    assign len_lo  = lit_sel ? cfg.on_min_ms : cfg.off_min_ms;
    assign len_hi  = lit_sel ? cfg.on_max_ms : cfg.off_max_ms;

    nalb_phase_len #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_len (
        .lo   (len_lo),
        .hi   (len_hi),
        .draw (item.random_draw),
        .len  (len)
    );

    assign tail_ext   = {{TIME_WIDTH{1'b0}}, cfg.tail_ms};
    assign tail_load  = (tail_ext > TMAX) ? {TIME_WIDTH{1'b1}} : tail_ext[TIME_WIDTH-1:0];
    assign budget_sum = {1'b0, budget_reg} + {1'b0, cfg.pulses_per_activity};

    always_comb
    begin
        link_next    = link_reg;
        open_next    = open_reg;
        budget_next  = budget_reg;
        tail_next    = tail_reg;
        phase_next   = phase_reg;
        is_lit_next  = is_lit_reg;
        running_next = running_reg;
        blink        = 1'b0;

        case (item.cmd)
            nalb_pkg::CMD_TICK:
            begin
                if (tail_reg != '0)
                begin
                    tail_next = tail_reg - TIME_WIDTH'(1);
                end
                if (phase_reg != '0)
                begin
                    phase_next = phase_reg - TIME_WIDTH'(1);
                end
                if (link_reg)
                begin
                    if (!((open_reg != '0) || (budget_reg != '0) || (tail_next != '0)))
                    begin
                        is_lit_next  = 1'b0;
                        running_next = 1'b0;
                        phase_next   = '0;
                    end
                    else if (!running_reg || (phase_next == '0))
                    begin
                        if (running_reg && is_lit_reg && (budget_reg != '0))
                        begin
                            budget_next = budget_reg - 8'd1;
                        end
                        is_lit_next  = lit_sel;
                        running_next = 1'b1;
                        phase_next   = len;
                    end
                end
            end
            nalb_pkg::CMD_LINK:
            begin
                link_next = item.connected;
                if (!item.connected)
                begin
                    budget_next  = '0;
                    tail_next    = '0;
                    is_lit_next  = 1'b0;
                    running_next = 1'b0;
                    phase_next   = '0;
                end
            end
            nalb_pkg::CMD_ACT_BEGIN:
            begin
                if (open_reg != nalb_pkg::DEPTH_MAX)
                begin
                    open_next = open_reg + 16'd1;
                end
                budget_next = (budget_sum > {1'b0, cfg.max_pulse_budget}) ?
                              cfg.max_pulse_budget : budget_sum[7:0];
                tail_next = tail_load;
                if (link_reg)
                begin
                    is_lit_next  = 1'b1;
                    running_next = 1'b1;
                    phase_next   = len;
                end
            end
            default:
            begin
                if (open_reg != '0)
                begin
                    open_next = open_reg - 16'd1;
                end
                tail_next = tail_load;
            end
        endcase

        // Every command other than a tick re-evaluates the blink condition afterwards while the link is up.
        if ((item.cmd != nalb_pkg::CMD_TICK) && link_next)
        begin
            if ((open_next != '0) || (budget_next != '0) || (tail_next != '0))
            begin
                if (!running_next)
                begin
                    is_lit_next  = 1'b1;
                    running_next = 1'b1;
                    phase_next   = len;
                end
            end
            else
            begin
                is_lit_next  = 1'b0;
                running_next = 1'b0;
                phase_next   = '0;
            end
        end

        blink = link_next && ((open_next != '0) || (budget_next != '0) || (tail_next != '0));
        res.led_lit        = !link_next || (blink && is_lit_next);
        res.phase_lit      = is_lit_next;
        res.blinking       = blink;
        res.pulses_left    = budget_next;
        res.activity_depth = open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= 1'b0;
            open_reg    <= '0;
            budget_reg  <= '0;
            tail_reg    <= '0;
            phase_reg   <= '0;
            is_lit_reg  <= 1'b0;
            running_reg <= 1'b0;
        end
        else if (step)
        begin
            link_reg    <= link_next;
            open_reg    <= open_next;
            budget_reg  <= budget_next;
            tail_reg    <= tail_next;
            phase_reg   <= phase_next;
            is_lit_reg  <= is_lit_next;
            running_reg <= running_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/network_activity_led_blinker.sv
// Top level of the network activity LED blinker: request register, settings and result register.
//
//   channel   direction   handshake              payload
//   in        to block    in_valid / in_ready    cmd, connected, random_draw
//   out       from block  out_valid / out_ready  led_lit, phase_lit, blinking,
//                                                pulses_left, activity_depth
//   cfg       to block    cfg_write              cfg_index, cfg_data
//
// A request is registered on acceptance and processed in the next cycle, when the
// result register is free; the result register takes its result in the cycle after that.
// Throughput is one request per cycle while out_ready keeps the result register free.
// Reset clears the blink state and loads the default settings; no clearing pass.
// A stalled result holds the request register, which then stops taking requests.
`default_nettype none

module network_activity_led_blinker #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic        connected,
    input  wire logic [15:0] random_draw,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             led_lit,
    output logic             phase_lit,
    output logic             blinking,
    output logic [7:0]       pulses_left,
    output logic [15:0]      activity_depth,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    nalb_pkg::cfg_t  cfg_reg;
    nalb_pkg::item_t item_reg;
    nalb_pkg::res_t  res_next;
    nalb_pkg::res_t  res_reg;
    logic            item_valid_reg;
    logic            out_valid_reg;
    logic            step;

    assign step     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_min_ms           <= 16'd50;
            cfg_reg.on_max_ms           <= 16'd120;
            cfg_reg.off_min_ms          <= 16'd50;
            cfg_reg.off_max_ms          <= 16'd120;
            cfg_reg.pulses_per_activity <= 8'd2;
            cfg_reg.max_pulse_budget    <= 8'd8;
            cfg_reg.tail_ms             <= 16'd300;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nalb_pkg::REG_ON_MIN:     cfg_reg.on_min_ms           <= cfg_data;
                nalb_pkg::REG_ON_MAX:     cfg_reg.on_max_ms           <= cfg_data;
                nalb_pkg::REG_OFF_MIN:    cfg_reg.off_min_ms          <= cfg_data;
                nalb_pkg::REG_OFF_MAX:    cfg_reg.off_max_ms          <= cfg_data;
                nalb_pkg::REG_PULSES:     cfg_reg.pulses_per_activity <= cfg_data[7:0];
                nalb_pkg::REG_MAX_BUDGET: cfg_reg.max_pulse_budget    <= cfg_data[7:0];
                nalb_pkg::REG_TAIL:       cfg_reg.tail_ms             <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                item_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd         <= cmd;
            item_reg.connected   <= connected;
            item_reg.random_draw <= random_draw;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    nalb_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    assign out_valid      = out_valid_reg;
    assign led_lit        = res_reg.led_lit;
    assign phase_lit      = res_reg.phase_lit;
    assign blinking       = res_reg.blinking;
    assign pulses_left    = res_reg.pulses_left;
    assign activity_depth = res_reg.activity_depth;

endmodule

`default_nettype wire
